/* hdl/lkvc_pkg.sv */
package lkvc_pkg;

  // field widths of the request and response items
  localparam int KEY_W   = 32;
  localparam int VALUE_W = 32;
  localparam int CAP_W   = 5;

  // operation of a request item
  typedef enum logic [0:0] {
    KIND_GET = 1'b0,
    KIND_SET = 1'b1
  } kind_t;

  typedef logic signed [KEY_W-1:0]   key_t;
  typedef logic signed [VALUE_W-1:0] value_t;
  typedef logic        [CAP_W-1:0]   cap_t;

  // capacity after reset, and the value returned on a miss
  localparam cap_t   CAP_RESET  = cap_t'(16);
  localparam value_t MISS_VALUE = '1;

endpackage

/* hdl/lkvc_req_if.sv */
interface lkvc_req_if;
  logic           valid;
  logic           ready;
  lkvc_pkg::kind_t  kind;
  lkvc_pkg::key_t   key;
  lkvc_pkg::value_t value;

  modport source (output valid, output kind, output key, output value, input ready);
  modport sink   (input valid, input kind, input key, input value, output ready);
endinterface

/* hdl/lkvc_rsp_if.sv */
interface lkvc_rsp_if;
  logic             valid;
  logic             ready;
  logic             hit;
  lkvc_pkg::value_t read_value;

  modport source (output valid, output hit, output read_value, input ready);
  modport sink   (input valid, input hit, input read_value, output ready);
endinterface

/* hdl/lru_key_value_cache.sv */
// Fully associative key-value cache with least-recently-used replacement.
//
// req channel: one item per get (kind KIND_GET) or set (kind KIND_SET) with
// a key and, for a set, a value. rsp channel: one item per get only, with
// hit and read_value (the stored value, or all ones on a miss). A set gives
// no response item.
// cfg_we / cfg_wdata write the capacity (entries in use before eviction);
// zero acts as one, anything above ENTRIES acts as ENTRIES. Write it only
// while no item is in flight.
//
// Timing: an accepted get passes the input register and then the response
// register. Throughput: one item per cycle while rsp is not held, set by
// the single pass of ENTRIES parallel key compares and the rank update
// between the input register and the response register.
// Reset: store empty, capacity 16; no clearing pass is needed.
// Stall: while rsp is held, a get waits in the input register and req.ready
// drops; a set in the input register still drains since it has no response.
module lru_key_value_cache #(
  parameter int ENTRIES = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  lkvc_pkg::cap_t    cfg_wdata,
  lkvc_req_if.sink          req,
  lkvc_rsp_if.source        rsp
);
  import lkvc_pkg::*;

  localparam int RW   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW   = $clog2(ENTRIES + 1);
  localparam int CAPW = (CW > CAP_W) ? CW : CAP_W;

  // entry storage
  key_t            entry_key   [ENTRIES];
  value_t          entry_value [ENTRIES];
  logic [RW-1:0]   entry_rank  [ENTRIES];
  logic [ENTRIES-1:0] entry_valid;
  logic [CW-1:0]   entry_count;
  cap_t            capacity;

  // input register
  logic   s1_valid;
  kind_t  s1_kind;
  key_t   s1_key;
  value_t s1_value;
  logic   s1_go;

  // response register
  logic   rsp_valid;
  logic   rsp_hit;
  value_t rsp_read_value;

  // lookup and update control
  logic [ENTRIES-1:0] match;
  logic [ENTRIES-1:0] victim;
  logic [ENTRIES-1:0] free_oh;
  logic [ENTRIES-1:0] tgt;
  logic               hit;
  value_t             hit_value;
  logic [RW-1:0]      hit_rank;
  logic [CAPW-1:0]    cap_ext;
  logic [CAPW-1:0]    eff_cap;
  logic               store_full;
  logic [CW-1:0]      r_sel;
  logic               do_update;
  logic               write_key;
  logic               write_value;
  logic               insert;

  // handshake
  assign s1_go     = s1_valid && (s1_kind == KIND_SET || !rsp_valid || rsp.ready);
  assign req.ready = !s1_valid || s1_go;

  assign rsp.valid      = rsp_valid;
  assign rsp.hit        = rsp_hit;
  assign rsp.read_value = rsp_read_value;

  // capacity register
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (cfg_we) begin
      capacity <= cfg_wdata;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req.valid && req.ready) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      s1_kind  <= req.kind;
      s1_key   <= req.key;
      s1_value <= req.value;
    end
  end

  // parallel key compare, value and rank of the matching entry
  always_comb begin
    match     = '0;
    hit_value = '0;
    hit_rank  = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      match[i] = entry_valid[i] && (entry_key[i] == s1_key);
      if (match[i]) begin
        hit_value = hit_value | entry_value[i];
        hit_rank  = hit_rank | entry_rank[i];
      end
    end
  end

  assign hit = |match;

  // least recent entry holds the rank entry_count - 1
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      victim[i] = entry_valid[i] && (CW'(entry_rank[i]) == CW'(entry_count - 1'b1));
    end
  end

  // lowest free slot
  assign free_oh = ~entry_valid & (entry_valid + ENTRIES'(1));

  // effective capacity and full check
  always_comb begin
    cap_ext = CAPW'(capacity);
    if (cap_ext == '0) begin
      eff_cap = CAPW'(1);
    end else if (cap_ext > CAPW'(ENTRIES)) begin
      eff_cap = CAPW'(ENTRIES);
    end else begin
      eff_cap = cap_ext;
    end
  end

  assign store_full = (CAPW'(entry_count) >= eff_cap) || (&entry_valid);

  // choose target entry and the rank below which entries age
  always_comb begin
    do_update   = s1_go && (s1_kind == KIND_SET || hit);
    write_key   = 1'b0;
    write_value = 1'b0;
    insert      = 1'b0;
    if (hit) begin
      tgt         = match;
      r_sel       = CW'(hit_rank);
      write_value = (s1_kind == KIND_SET);
    end else if (store_full) begin
      tgt         = victim;
      r_sel       = CW'(entry_count - 1'b1);
      write_key   = 1'b1;
      write_value = 1'b1;
    end else begin
      tgt         = free_oh;
      r_sel       = entry_count;
      write_key   = 1'b1;
      write_value = 1'b1;
      insert      = 1'b1;
    end
  end

  // entry payload and rank update
  always_ff @(posedge clk) begin
    if (do_update) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (tgt[i]) begin
          entry_rank[i] <= '0;
          if (write_key) begin
            entry_key[i] <= s1_key;
          end
          if (write_value) begin
            entry_value[i] <= s1_value;
          end
        end else if (entry_valid[i] && (CW'(entry_rank[i]) < r_sel)) begin
          entry_rank[i] <= RW'(entry_rank[i] + 1'b1);
        end
      end
    end
  end

  // valid bits and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      entry_count <= '0;
    end else if (do_update && insert) begin
      entry_valid <= entry_valid | tgt;
      entry_count <= CW'(entry_count + 1'b1);
    end
  end

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (s1_go && s1_kind == KIND_GET) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_kind == KIND_GET) begin
      rsp_hit        <= hit;
      rsp_read_value <= hit ? hit_value : MISS_VALUE;
    end
  end

  // fill count tracks the valid bits
  a_count_matches_valid: assert property (@(posedge clk) disable iff (rst)
    $countones(entry_valid) == int'(entry_count))
    else $error("fill count differs from number of valid entries");

  // a key lives in at most one entry
  a_key_unique: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> $onehot0(match))
    else $error("key found in more than one entry");

  // a get that leaves the input register shows up as a response
  a_get_responds: assert property (@(posedge clk) disable iff (rst)
    (s1_go && s1_kind == KIND_GET) |=> rsp.valid)
    else $error("get item produced no response");

  // an update always has exactly one target entry
  a_one_target: assert property (@(posedge clk) disable iff (rst)
    do_update |-> $onehot(tgt))
    else $error("update without a single target entry");

endmodule
